// File: design/blm_pkg.sv
// Types, constants and helpers shared by the Brent line minimizer.
// No dependencies.
package blm_pkg;

   localparam int unsigned CGOLD_Q16 = 25033;
   localparam logic [15:0] REL_TOL_RESET = 16'd7;
   localparam int unsigned DIV_STEPS = 48;
   localparam int unsigned CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [4:0] {
      ST_IDLE, ST_TOL_MUL, ST_TOL_SET, ST_CHECK,
      ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9,
      ST_DECIDE, ST_DIV_INIT, ST_DIV_STEP, ST_DIV_END, ST_ADJ,
      ST_GOLD, ST_GOLD_MUL, ST_GOLD_END, ST_FINAL
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_TOL_MUL, OP_TOL_SET, OP_CHECK,
      OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7, OP_M8, OP_M9,
      OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END, OP_ADJ,
      OP_GOLD, OP_GOLD_MUL, OP_GOLD_END, OP_FINAL
   } op_type;

   typedef struct packed {
      op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic parab;
      logic reject;
      logic div_last;
      logic out_free;
   } dp_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -68'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
      return {{2{v[31]}}, v};
   endfunction

endpackage

// File: design/brent_line_minimizer_step_top.sv
// Top level of the Brent line minimizer step engine.
// Depends on blm_pkg, blm_ctrl and blm_dp.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | cmd, end_one, end_two, start_x, start_f, eval_f
//  rsp     | out       | rsp_valid/rsp_stall | next_x, best_x, best_f, done_res
//  csr     | in        | csr_valid/csr_ready | rel_tolerance
//
// A request runs the tolerance and check steps and then, on the plain path, the
// golden-section steps; when the parabola is tried the parabola multiply steps come
// first, and when it is taken the 48-step serial divider and the end adjustment replace
// the golden-section steps. The multiply steps share one 34x34 multiplier. One request
// is in work at a time; req_stall is high from acceptance until the result is posted
// to the output register. A stalled result holds the block in its last step only when
// the next result is ready. Reset is synchronous and clears the search state to zero
// and rel_tolerance to 7; csr_ready is always high.
module brent_line_minimizer_step_top import blm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [31:0] req_end_one,
   input  logic signed [31:0] req_end_two,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_f,
   input  logic signed [31:0] req_eval_f,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_next_x,
   output logic signed [31:0] rsp_best_x,
   output logic signed [31:0] rsp_best_f,
   output logic               rsp_done_res,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_rel_tolerance
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   blm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   blm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_cmd           (req_cmd),
      .req_end_one       (req_end_one),
      .req_end_two       (req_end_two),
      .req_start_x       (req_start_x),
      .req_start_f       (req_start_f),
      .req_eval_f        (req_eval_f),
      .csr_valid         (csr_valid & csr_ready),
      .csr_rel_tolerance (csr_rel_tolerance),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_next_x        (rsp_next_x),
      .rsp_best_x        (rsp_best_x),
      .rsp_best_f        (rsp_best_f),
      .rsp_done_res      (rsp_done_res)
   );

endmodule

// File: design/blm_ctrl.sv
// Sequencer of the Brent line minimizer: walks one request through its micro-steps.
// Depends on blm_pkg.
module blm_ctrl import blm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_TOL_MUL;
         ST_TOL_MUL:  state_in = ST_TOL_SET;
         ST_TOL_SET:  state_in = ST_CHECK;
         ST_CHECK:    state_in = status.parab ? ST_M1 : ST_GOLD;
         ST_M1:       state_in = ST_M2;
         ST_M2:       state_in = ST_M3;
         ST_M3:       state_in = ST_M4;
         ST_M4:       state_in = ST_M5;
         ST_M5:       state_in = ST_M6;
         ST_M6:       state_in = ST_M7;
         ST_M7:       state_in = ST_M8;
         ST_M8:       state_in = ST_M9;
         ST_M9:       state_in = ST_DECIDE;
         ST_DECIDE:   state_in = status.reject ? ST_GOLD : ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV_STEP;
         ST_DIV_STEP: if (status.div_last) state_in = ST_DIV_END;
         ST_DIV_END:  state_in = ST_ADJ;
         ST_ADJ:      state_in = ST_FINAL;
         ST_GOLD:     state_in = ST_GOLD_MUL;
         ST_GOLD_MUL: state_in = ST_GOLD_END;
         ST_GOLD_END: state_in = ST_FINAL;
         ST_FINAL:    if (status.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = OP_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = OP_ACCEPT;
         end
         ST_TOL_MUL:  cmd.op = OP_TOL_MUL;
         ST_TOL_SET:  cmd.op = OP_TOL_SET;
         ST_CHECK:    cmd.op = OP_CHECK;
         ST_M1:       cmd.op = OP_M1;
         ST_M2:       cmd.op = OP_M2;
         ST_M3:       cmd.op = OP_M3;
         ST_M4:       cmd.op = OP_M4;
         ST_M5:       cmd.op = OP_M5;
         ST_M6:       cmd.op = OP_M6;
         ST_M7:       cmd.op = OP_M7;
         ST_M8:       cmd.op = OP_M8;
         ST_M9:       cmd.op = OP_M9;
         ST_DECIDE:   cmd.op = OP_NONE;
         ST_DIV_INIT: cmd.op = OP_DIV_INIT;
         ST_DIV_STEP: cmd.op = OP_DIV_STEP;
         ST_DIV_END:  cmd.op = OP_DIV_END;
         ST_ADJ:      cmd.op = OP_ADJ;
         ST_GOLD:     cmd.op = OP_GOLD;
         ST_GOLD_MUL: cmd.op = OP_GOLD_MUL;
         ST_GOLD_END: cmd.op = OP_GOLD_END;
         ST_FINAL:    if (status.out_free) cmd.op = OP_FINAL;
         default:     cmd.op = OP_NONE;
      endcase
   end

endmodule

// File: design/blm_dp.sv
// Datapath of the Brent line minimizer: state, shared multiplier, serial divider.
// Depends on blm_pkg; driven by blm_ctrl commands.
module blm_dp import blm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   output dp_status_type       status,
   input  logic                req_cmd,
   input  logic signed [31:0]  req_end_one,
   input  logic signed [31:0]  req_end_two,
   input  logic signed [31:0]  req_start_x,
   input  logic signed [31:0]  req_start_f,
   input  logic signed [31:0]  req_eval_f,
   input  logic                csr_valid,
   input  logic [15:0]         csr_rel_tolerance,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_next_x,
   output logic signed [31:0]  rsp_best_x,
   output logic signed [31:0]  rsp_best_f,
   output logic                rsp_done_res
);

   logic [15:0] rel_ff;
   logic signed [31:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [31:0] xb_ff, xb_in, xw_ff, xw_in, xv_ff, xv_in;
   logic signed [31:0] fb_ff, fb_in, fw_ff, fw_in, fv_ff, fv_in;
   logic signed [31:0] sbl_ff, sbl_in, ls_ff, ls_in, pend_ff, pend_in;
   logic signed [67:0] prod_ff, prod_in;
   logic signed [33:0] mul_a, mul_b;
   logic signed [33:0] tol1_ff, tol1_in;
   logic               done_ff, done_in;
   logic signed [31:0] mid_ff, mid_in;
   logic signed [31:0] dxw_ff, dxw_in, dxv_ff, dxv_in, dfv_ff, dfv_in, dfw_ff, dfw_in;
   logic signed [31:0] r_ff, r_in, q0_ff, q0_in;
   logic signed [51:0] m2_ff, m2_in;
   logic signed [32:0] p_ff, p_in;
   logic signed [33:0] q_ff, q_in;
   logic signed [31:0] et_ff, et_in, am_ff, am_in, bm_ff, bm_in;
   logic signed [50:0] lim_ff, lim_in;
   logic signed [67:0] cam_ff, cam_in, cbm_ff, cbm_in;
   logic [47:0]        dnum_ff, dnum_in;
   logic [31:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [31:0] d_ff, d_in;
   logic               rv_ff, rv_in;
   logic signed [31:0] nx_ff, nx_in, bx_ff, bx_in, bf_ff, bf_in;
   logic               dn_ff, dn_in;

   logic signed [32:0] sum_c, abs_xb, hl_c;
   logic signed [31:0] mid_c;
   logic signed [35:0] dm_c, abs_dm, rhs_c;
   logic signed [32:0] abs_sbl, abs_p, abs_et, abs_d;
   logic signed [51:0] m1_c;
   logic signed [31:0] praw_c, qraw_c;
   logic signed [48:0] psh_c;
   logic [32:0]        trial_c;
   logic signed [35:0] u_c, t2_c;
   logic signed [67:0] qs_c;

   assign sum_c  = 33'(lo_ff) + 33'(hi_ff);
   assign mid_c  = sum_c[32:1];
   assign hl_c   = 33'(hi_ff) - 33'(lo_ff);
   assign abs_xb = xb_ff[31] ? -33'(xb_ff) : 33'(xb_ff);
   assign dm_c   = 36'(xb_ff) - 36'(mid_c);
   assign abs_dm = dm_c[35] ? -dm_c : dm_c;
   assign rhs_c  = (36'(tol1_ff) <<< 1) - 36'($signed(hl_c[32:1]));
   assign abs_sbl = sbl_ff[31] ? -33'(sbl_ff) : 33'(sbl_ff);
   assign abs_p   = p_ff[32] ? -p_ff : p_ff;
   assign abs_et  = et_ff[31] ? -33'(et_ff) : 33'(et_ff);
   assign abs_d   = d_ff[31] ? -33'(d_ff) : 33'(d_ff);
   assign m1_c    = 52'(prod_ff >>> 16);
   assign praw_c  = sat32(68'(m1_c) - 68'(m2_ff));
   assign qraw_c  = sat32((68'(q0_ff) - 68'(r_ff)) <<< 1);
   assign psh_c   = 49'(p_ff) <<< 16;
   assign trial_c = {rem_ff, dnum_ff[47]};
   assign u_c     = 36'(xb_ff) + 36'(d_ff);
   assign t2_c    = 36'(tol1_ff) <<< 1;
   assign qs_c    = p_ff[32] ? -$signed({20'b0, dnum_ff}) : $signed({20'b0, dnum_ff});
   assign prod_in = mul_a * mul_b;

   assign status.parab    = abs_sbl > 33'(tol1_ff);
   assign status.reject   = (q_ff == 34'sd0) || (51'(abs_p) >= lim_ff) ||
                            (68'(psh_c) <= cam_ff) || (68'(psh_c) >= cbm_ff);
   assign status.div_last = cnt_ff == CNT_W'(DIV_STEPS - 1);
   assign status.out_free = !rv_ff || !rsp_stall;

   always_comb begin
      lo_in = lo_ff; hi_in = hi_ff; xb_in = xb_ff; xw_in = xw_ff; xv_in = xv_ff;
      fb_in = fb_ff; fw_in = fw_ff; fv_in = fv_ff;
      sbl_in = sbl_ff; ls_in = ls_ff; pend_in = pend_ff;
      tol1_in = tol1_ff; done_in = done_ff; mid_in = mid_ff;
      dxw_in = dxw_ff; dxv_in = dxv_ff; dfv_in = dfv_ff; dfw_in = dfw_ff;
      r_in = r_ff; q0_in = q0_ff; m2_in = m2_ff; p_in = p_ff; q_in = q_ff;
      et_in = et_ff; am_in = am_ff; bm_in = bm_ff; lim_in = lim_ff;
      cam_in = cam_ff; cbm_in = cbm_ff;
      dnum_in = dnum_ff; rem_in = rem_ff; cnt_in = cnt_ff; d_in = d_ff;
      nx_in = nx_ff; bx_in = bx_ff; bf_in = bf_ff; dn_in = dn_ff;
      mul_a = '0; mul_b = '0;
      rv_in = (rv_ff && !rsp_stall) ? 1'b0 : rv_ff;
      unique case (cmd.op)
         OP_NONE: ;
         OP_ACCEPT: begin
            if (!req_cmd) begin
               lo_in = (req_end_one < req_end_two) ? req_end_one : req_end_two;
               hi_in = (req_end_one > req_end_two) ? req_end_one : req_end_two;
               xb_in = req_start_x; xw_in = req_start_x; xv_in = req_start_x;
               fb_in = req_start_f; fw_in = req_start_f; fv_in = req_start_f;
               sbl_in = '0; ls_in = '0;
            end else if (req_eval_f <= fb_ff) begin
               if (pend_ff >= xb_ff) lo_in = xb_ff;
               else hi_in = xb_ff;
               xv_in = xw_ff; xw_in = xb_ff; xb_in = pend_ff;
               fv_in = fw_ff; fw_in = fb_ff; fb_in = req_eval_f;
            end else begin
               if (pend_ff < xb_ff) lo_in = pend_ff;
               else hi_in = pend_ff;
               if (req_eval_f <= fw_ff || xw_ff == xb_ff) begin
                  xv_in = xw_ff; xw_in = pend_ff;
                  fv_in = fw_ff; fw_in = req_eval_f;
               end else if (req_eval_f <= fv_ff || xv_ff == xb_ff || xv_ff == xw_ff) begin
                  xv_in = pend_ff; fv_in = req_eval_f;
               end
            end
         end
         OP_TOL_MUL: begin
            mul_a = {18'b0, rel_ff};
            mul_b = 34'(abs_xb);
         end
         OP_TOL_SET: tol1_in = $signed({3'b0, prod_ff[46:16]}) + 34'sd1;
         OP_CHECK: begin
            done_in = abs_dm <= rhs_c;
            mid_in = mid_c;
            dxw_in = sat32(68'(xb_ff) - 68'(xw_ff));
            dxv_in = sat32(68'(xb_ff) - 68'(xv_ff));
            dfv_in = sat32(68'(fb_ff) - 68'(fv_ff));
            dfw_in = sat32(68'(fb_ff) - 68'(fw_ff));
         end
         OP_M1: begin
            mul_a = sx34(dxw_ff); mul_b = sx34(dfv_ff);
         end
         OP_M2: begin
            r_in = sat32(prod_ff >>> 16);
            mul_a = sx34(dxv_ff); mul_b = sx34(dfw_ff);
         end
         OP_M3: begin
            q0_in = sat32(prod_ff >>> 16);
            mul_a = sx34(dxw_ff); mul_b = sx34(r_ff);
         end
         OP_M4: begin
            m2_in = 52'(prod_ff >>> 16);
            mul_a = sx34(dxv_ff); mul_b = sx34(q0_ff);
         end
         OP_M5: begin
            p_in = (qraw_c > 32'sd0) ? -33'(praw_c) : 33'(praw_c);
            q_in = qraw_c[31] ? -34'(qraw_c) : 34'(qraw_c);
            et_in = sbl_ff;
            sbl_in = ls_ff;
            am_in = sat32(68'(lo_ff) - 68'(xb_ff));
            bm_in = sat32(68'(hi_ff) - 68'(xb_ff));
         end
         OP_M6: begin
            mul_a = q_ff; mul_b = 34'(abs_et);
         end
         OP_M7: begin
            lim_in = 51'(prod_ff >>> 17);
            mul_a = q_ff; mul_b = sx34(am_ff);
         end
         OP_M8: begin
            cam_in = prod_ff;
            mul_a = q_ff; mul_b = sx34(bm_ff);
         end
         OP_M9: cbm_in = prod_ff;
         OP_DIV_INIT: begin
            dnum_in = {abs_p[31:0], 16'b0};
            rem_in = '0;
            cnt_in = '0;
         end
         OP_DIV_STEP: begin
            if (trial_c >= {1'b0, q_ff[31:0]}) begin
               rem_in = 32'(trial_c - {1'b0, q_ff[31:0]});
               dnum_in = {dnum_ff[46:0], 1'b1};
            end else begin
               rem_in = trial_c[31:0];
               dnum_in = {dnum_ff[46:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         OP_DIV_END: d_in = sat32(qs_c);
         OP_ADJ: begin
            if ((u_c - 36'(lo_ff)) < t2_c || (36'(hi_ff) - u_c) < t2_c) begin
               if ((33'(mid_ff) - 33'(xb_ff)) >= 33'sd0) d_in = sat32(68'(tol1_ff));
               else d_in = sat32(-68'(tol1_ff));
            end
         end
         OP_GOLD: begin
            if (xb_ff >= mid_ff) sbl_in = sat32(68'(lo_ff) - 68'(xb_ff));
            else sbl_in = sat32(68'(hi_ff) - 68'(xb_ff));
         end
         OP_GOLD_MUL: begin
            mul_a = sx34(sbl_ff);
            mul_b = 34'(CGOLD_Q16);
         end
         OP_GOLD_END: d_in = 32'(prod_ff >>> 16);
         OP_FINAL: begin
            ls_in = d_ff;
            if (abs_d >= 33'(tol1_ff)) pend_in = sat32(68'(u_c));
            else if (!d_ff[31]) pend_in = sat32(68'(xb_ff) + 68'(tol1_ff));
            else pend_in = sat32(68'(xb_ff) - 68'(tol1_ff));
            nx_in = pend_in;
            bx_in = xb_ff;
            bf_in = fb_ff;
            dn_in = done_ff;
            rv_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_ff <= REL_TOL_RESET;
         rv_ff <= 1'b0;
         lo_ff <= '0; hi_ff <= '0; xb_ff <= '0; xw_ff <= '0; xv_ff <= '0;
         fb_ff <= '0; fw_ff <= '0; fv_ff <= '0;
         sbl_ff <= '0; ls_ff <= '0; pend_ff <= '0;
      end else begin
         if (csr_valid) rel_ff <= csr_rel_tolerance;
         rv_ff <= rv_in;
         lo_ff <= lo_in; hi_ff <= hi_in; xb_ff <= xb_in; xw_ff <= xw_in; xv_ff <= xv_in;
         fb_ff <= fb_in; fw_ff <= fw_in; fv_ff <= fv_in;
         sbl_ff <= sbl_in; ls_ff <= ls_in; pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in; tol1_ff <= tol1_in; done_ff <= done_in; mid_ff <= mid_in;
      dxw_ff <= dxw_in; dxv_ff <= dxv_in; dfv_ff <= dfv_in; dfw_ff <= dfw_in;
      r_ff <= r_in; q0_ff <= q0_in; m2_ff <= m2_in; p_ff <= p_in; q_ff <= q_in;
      et_ff <= et_in; am_ff <= am_in; bm_ff <= bm_in; lim_ff <= lim_in;
      cam_ff <= cam_in; cbm_ff <= cbm_in;
      dnum_ff <= dnum_in; rem_ff <= rem_in; cnt_ff <= cnt_in; d_ff <= d_in;
      nx_ff <= nx_in; bx_ff <= bx_in; bf_ff <= bf_in; dn_ff <= dn_in;
   end

   assign rsp_valid    = rv_ff;
   assign rsp_next_x   = nx_ff;
   assign rsp_best_x   = bx_ff;
   assign rsp_best_f   = bf_ff;
   assign rsp_done_res = dn_ff;

endmodule

// File: design/blm_checker.sv
// Port-level assertions for the Brent line minimizer top level, and their bind.
// Depends on brent_line_minimizer_step_top.
module blm_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_next_x
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after accepting a request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_x))
      else $error("stalled result changed");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result posted without work in progress");

   a_idle_posts: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> rsp_valid)
      else $error("returned to idle without posting a result");

endmodule

bind brent_line_minimizer_step_top blm_port_checker u_blm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_next_x (rsp_next_x)
);

// File: tb/blm_checker.sv
// Checker for the Brent line minimizer: watches the req, rsp and csr channels,
// predicts each response from its own copy of the search state and compares.
// Depends on blm_pkg for the golden-section and reset tolerance constants.
module blm_checker import blm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [31:0] req_end_one,
   input  logic signed [31:0] req_end_two,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_f,
   input  logic signed [31:0] req_eval_f,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_next_x,
   input  logic signed [31:0] rsp_best_x,
   input  logic signed [31:0] rsp_best_f,
   input  logic               rsp_done_res,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [15:0]        csr_rel_tolerance,
   output int                 fail_count,
   output int                 awaited
);

   typedef struct {
      logic signed [31:0] next_x;
      logic signed [31:0] best_x;
      logic signed [31:0] best_f;
      logic               done;
   } proposal_type;

   proposal_type proposal_q[$];

   longint rel_tol;
   longint lo, hi, xb, xw, xv, fb, fw, fv, e_prev, d_last, u_pend;

   function automatic longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint fdiv(longint v, longint d);
      if (v >= 0) return v / d;
      return -((-v + d - 1) / d);
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return fdiv(a * b, 65536);
   endfunction

   function automatic longint tol_unit();
      return ((rel_tol * mag(xb)) >>> 16) + 1;
   endfunction

   function automatic longint golden_step(longint xm);
      e_prev = sat(xb >= xm ? lo - xb : hi - xb);
      return qmul(e_prev, CGOLD_Q16);
   endfunction

   task automatic propose_next();
      longint xm, tol1, tol2, d, u, dxw, dxv, dfv, dfw, r, q0, p, q, et, lim, am, bm;
      xm = fdiv(lo + hi, 2);
      tol1 = tol_unit();
      tol2 = 2 * tol1;
      if (mag(e_prev) > tol1) begin
         dxw = sat(xb - xw);
         dxv = sat(xb - xv);
         dfv = sat(fb - fv);
         dfw = sat(fb - fw);
         r = sat(qmul(dxw, dfv));
         q0 = sat(qmul(dxv, dfw));
         p = sat(qmul(dxv, q0) - qmul(dxw, r));
         q = sat(2 * (q0 - r));
         if (q > 0) p = -p;
         q = mag(q);
         et = e_prev;
         e_prev = d_last;
         lim = (q * mag(et)) >>> 17;
         am = sat(lo - xb);
         bm = sat(hi - xb);
         if (q == 0 || mag(p) >= lim || p * 65536 <= q * am || p * 65536 >= q * bm) begin
            d = golden_step(xm);
         end else begin
            d = sat((p * 65536) / q);
            u = xb + d;
            if (u - lo < tol2 || hi - u < tol2) d = sat(xm - xb >= 0 ? tol1 : -tol1);
         end
      end else begin
         d = golden_step(xm);
      end
      d_last = d;
      if (mag(d) >= tol1) u = xb + d;
      else u = xb + (d >= 0 ? tol1 : -tol1);
      u_pend = sat(u);
   endtask

   task automatic search_step();
      proposal_type pr;
      longint e1, e2, fu, u, x, xm, tol2;
      if (!req_cmd) begin
         e1 = req_end_one;
         e2 = req_end_two;
         lo = e1 < e2 ? e1 : e2;
         hi = e1 > e2 ? e1 : e2;
         xb = req_start_x; xw = xb; xv = xb;
         fb = req_start_f; fw = fb; fv = fb;
         e_prev = 0;
         d_last = 0;
      end else begin
         u = u_pend;
         fu = req_eval_f;
         x = xb;
         if (fu <= fb) begin
            if (u >= x) lo = x; else hi = x;
            xv = xw; xw = x; xb = u;
            fv = fw; fw = fb; fb = fu;
         end else begin
            if (u < x) lo = u; else hi = u;
            if (fu <= fw || xw == x) begin
               xv = xw; xw = u;
               fv = fw; fw = fu;
            end else if (fu <= fv || xv == x || xv == xw) begin
               xv = u;
               fv = fu;
            end
         end
      end
      xm = fdiv(lo + hi, 2);
      tol2 = 2 * tol_unit();
      pr.done = mag(xb - xm) <= tol2 - fdiv(hi - lo, 2);
      propose_next();
      pr.next_x = u_pend[31:0];
      pr.best_x = xb[31:0];
      pr.best_f = fb[31:0];
      proposal_q.push_back(pr);
   endtask

   always @(posedge clock) begin
      proposal_type pr;
      if (reset) begin
         rel_tol = REL_TOL_RESET;
         {lo, hi, xb, xw, xv} = '0;
         {fb, fw, fv, e_prev, d_last, u_pend} = '0;
         proposal_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (proposal_q.size() == 0) begin
               $display("%0t: response with nothing expected, next_x %0d", $time, rsp_next_x);
               fail_count <= fail_count + 1;
            end else begin
               pr = proposal_q.pop_front();
               if (pr.next_x !== rsp_next_x || pr.best_x !== rsp_best_x ||
                   pr.best_f !== rsp_best_f || pr.done !== rsp_done_res) begin
                  $display("%0t: expected next %0d best %0d f %0d done %0b, got %0d %0d %0d %0b",
                           $time, pr.next_x, pr.best_x, pr.best_f, pr.done,
                           rsp_next_x, rsp_best_x, rsp_best_f, rsp_done_res);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_valid && csr_ready) rel_tol = csr_rel_tolerance;
         if (req_valid && !req_stall) search_step();
      end
      awaited <= proposal_q.size();
   end

endmodule

// File: tb/tb_top.sv
// Testbench top for the Brent line minimizer step engine: clock, reset,
// request and tolerance stimulus, response stalls and the verdict.
// Depends on blm_pkg, brent_line_minimizer_step_top and blm_checker.
module tb_top;
   import blm_pkg::*;

   logic               clock = 0;
   logic               reset;
   logic               req_valid, req_stall, req_cmd;
   logic signed [31:0] req_end_one, req_end_two, req_start_x, req_start_f, req_eval_f;
   logic               rsp_valid, rsp_stall, rsp_done_res;
   logic signed [31:0] rsp_next_x, rsp_best_x, rsp_best_f;
   logic               csr_valid, csr_ready;
   logic [15:0]        csr_rel_tolerance;
   int                 fail_count, awaited;
   int                 sent, answered, idle_cycles;
   bit                 stall_on;
   int                 stall_left;
   logic signed [31:0] last_next;
   longint             center;

   always #10 clock = ~clock;

   brent_line_minimizer_step_top dut (.*);

   blm_checker chk (.*);

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 65) return 0;
      if (k < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         stall_left <= 0;
         answered <= 0;
         last_next <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            answered <= answered + 1;
            last_next <= rsp_next_x;
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
            if (stall_on) stall_left <= gap_len();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 5000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send(bit cmd, logic signed [31:0] e1, logic signed [31:0] e2,
                       logic signed [31:0] sx, logic signed [31:0] sf,
                       logic signed [31:0] ef);
      repeat (gap_len() + 1) @(posedge clock);
      req_valid <= 1;
      req_cmd <= cmd;
      req_end_one <= e1;
      req_end_two <= e2;
      req_start_x <= sx;
      req_start_f <= sf;
      req_eval_f <= ef;
      do @(posedge clock); while (req_stall);
      sent++;
      req_valid <= 0;
   endtask

   task automatic send_eval(logic signed [31:0] ef);
      send(1'b1, $urandom, $urandom, $urandom, $urandom, ef);
   endtask

   function automatic logic signed [31:0] bowl(longint x);
      longint v;
      v = (((x - center) * (x - center)) >>> 16) - 64'sd100000;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      return 32'(v);
   endfunction

   task automatic drain();
      wait (answered == sent && awaited == 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_tol(logic [15:0] t);
      csr_valid <= 1;
      csr_rel_tolerance <= t;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic random_phase(int n);
      int k, m;
      longint lo, span, x;
      k = 0;
      while (k < n) begin
         if ($urandom_range(0, 9) < 8) begin
            span = $urandom_range(2, 1 << 24);
            lo = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
            x = lo + $urandom_range(1, 32'(span - 1));
            center = lo + $urandom_range(0, 32'(span));
            if ($urandom_range(0, 1)) send(1'b0, 32'(lo), 32'(lo + span), 32'(x), bowl(x),
                                           $urandom);
            else send(1'b0, 32'(lo + span), 32'(lo), 32'(x), bowl(x), $urandom);
            m = $urandom_range(4, 25);
            k++;
            repeat (m) begin
               wait (answered == sent);
               if ($urandom_range(0, 19) == 0) send_eval($urandom);
               else send_eval(bowl(last_next));
               k++;
            end
         end else begin
            send(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom, $urandom);
            k++;
         end
      end
   endtask

   initial begin
      reset <= 1;
      req_valid <= 0;
      req_cmd <= 0;
      req_end_one <= 0;
      req_end_two <= 0;
      req_start_x <= 0;
      req_start_f <= 0;
      req_eval_f <= 0;
      csr_valid <= 0;
      csr_rel_tolerance <= 0;
      stall_on = 0;
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_eval(0);
      send_eval(32'sh7FFFFFFF);
      send_eval(32'sh80000000);
      send(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh80000000, 0);
      send_eval(32'sh7FFFFFFF);
      send_eval(32'sh80000000);
      send_eval(32'sh80000000);
      send(1'b0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
      send_eval(0);
      send_eval(0);
      send(1'b0, 100, -100, 5000000, 0, 0);
      send_eval(-1);
      send_eval(-1);
      send(1'b0, 65536, 65536, 65536, 65536, 0);
      send_eval(65536);
      send(1'b0, -65536, 65536, 10, 4, 0);
      send_eval(4);
      send_eval(5);
      send_eval(3);
      drain();

      write_tol(16'd0);
      random_phase(270);
      drain();
      write_tol(16'd65535);
      stall_on = 1;
      random_phase(270);
      drain();
      write_tol(16'd1);
      random_phase(270);
      drain();
      write_tol(16'($urandom_range(0, 65535)));
      stall_on = 0;
      random_phase(270);
      drain();
      write_tol(16'd7);
      stall_on = 1;
      random_phase(270);
      drain();

      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
